@@ rtl/core/multi_channel_servo_pwm_core_defines.svh @@
// ----------------------------------------------------------------------------
// servo pwm assertion macros
// shared concurrent assertion forms, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SERVO_PWM_CORE_DEFINES_SVH
`define MULTI_CHANNEL_SERVO_PWM_CORE_DEFINES_SVH

// same-cycle implication
`define MSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo pwm check failed");

// next-cycle implication
`define MSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo pwm check failed");

`endif

@@ rtl/core/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg
// shared types and constants of the multi-channel servo pwm core
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int CHANNELS  = 18;
    localparam int DUTY_BITS = 8;
    localparam int CH_W      = 5;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [DUTY_BITS-1:0] DUTY_RESET      = DUTY_BITS'(128);
    localparam logic [TICK_W-1:0]    LEAD_TICKS_RESET = 16'd254;
    localparam logic [TICK_W-1:0]    TAIL_TICKS_RESET = 16'd9457;

    // last modulation step, one more ends the modulating phase
    localparam logic [TICK_W:0] STEP_LAST = (TICK_W+1)'((1 << DUTY_BITS) - 1);

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_TICKS = 1'b1;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_MOD  = 2'd1,
        PH_TAIL = 2'd2
    } phase_t;

    typedef struct packed {
        logic                 kind;
        logic [CH_W-1:0]      channel;
        logic [DUTY_BITS-1:0] duty_value;
    } msp_in_t;

    typedef struct packed {
        logic [CHANNELS-1:0] servo_lines;
        logic [1:0]          frame_phase;
    } msp_out_t;

    typedef struct packed {
        logic [TICK_W-1:0] lead_ticks;
        logic [TICK_W-1:0] tail_ticks;
    } msp_timing_t;

    typedef struct packed {
        logic [CHANNELS-1:0] lines;
        phase_t              phase;
    } msp_frame_t;

endpackage

@@ rtl/core/msp_duty_table.sv @@
// ----------------------------------------------------------------------------
// msp_duty_table
// per-channel duty registers with a parallel step compare
// ----------------------------------------------------------------------------
module msp_duty_table
    import msp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CH_W-1:0]      wr_channel,
    input  logic [DUTY_BITS-1:0] wr_duty,
    input  logic [DUTY_BITS-1:0] step,
    output logic [CHANNELS-1:0]  match
);

    logic [DUTY_BITS-1:0] duty_reg [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                duty_reg[i] <= DUTY_RESET;
            end
        end
        else if (wr_en && (int'(wr_channel) < CHANNELS))
        begin
            duty_reg[wr_channel] <= wr_duty;
        end
    end

    // duty zero never equals a live step, so no special case here
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            match[i] = (duty_reg[i] == step);
        end
    end

endmodule

@@ rtl/core/msp_frame_seq.sv @@
// ----------------------------------------------------------------------------
// msp_frame_seq
// lead / modulate / tail sequencer holding phase, step count and line levels
// ----------------------------------------------------------------------------
module msp_frame_seq
    import msp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  msp_timing_t          timing,
    input  logic [CHANNELS-1:0]  match,
    output logic [DUTY_BITS-1:0] step,
    output msp_frame_t           cur,
    output msp_frame_t           nxt
);

    phase_t              phase_reg,  phase_next;
    logic [TICK_W-1:0]   count_reg,  count_next;
    logic [CHANNELS-1:0] lines_reg,  lines_next;
    logic [TICK_W:0]     count_inc;

    assign count_inc = {1'b0, count_reg} + (TICK_W+1)'(1);
    assign step      = count_inc[DUTY_BITS-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        lines_next = lines_reg;
        if (tick)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    // a length of zero behaves as one
                    if (count_inc >= {1'b0, timing.lead_ticks})
                    begin
                        phase_next = PH_MOD;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc[TICK_W-1:0];
                    end
                end
                PH_MOD:
                begin
                    if (count_inc > STEP_LAST)
                    begin
                        lines_next = '0;
                        phase_next = PH_TAIL;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc[TICK_W-1:0];
                        lines_next = lines_reg & ~match;
                    end
                end
                default:
                begin
                    if (count_inc >= {1'b0, timing.tail_ticks})
                    begin
                        lines_next = '1;
                        phase_next = PH_LEAD;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc[TICK_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAIL;
            count_reg <= '0;
            lines_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            lines_reg <= lines_next;
        end
    end

    assign cur.lines = lines_reg;
    assign cur.phase = phase_reg;
    assign nxt.lines = lines_next;
    assign nxt.phase = phase_next;

endmodule

@@ rtl/core/multi_channel_servo_pwm_core.sv @@
// an accepted word's result word is registered and appears on rsp in the next cycle
// throughput: one word per clock while rsp_ready is high, set by the single register stage on rsp
// every word (tick or duty write) yields exactly one result word
// reset: frame starts in the tail phase with all lines low, duties at 128,
// lead length 254 ticks and tail length 9457 ticks
// ----------------------------------------------------------------------------
// multi_channel_servo_pwm_core
// eighteen-channel servo pulse generator advanced by tick words
// ----------------------------------------------------------------------------
`include "multi_channel_servo_pwm_core_defines.svh"

module multi_channel_servo_pwm_core
    import msp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request words: ticks and duty writes
    input  logic                 req_valid,
    output logic                 req_ready,
    input  msp_in_t              req_word,
    // result words: line levels and phase after each request
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output msp_out_t             rsp_word,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    logic                 fire;
    logic                 is_tick;
    logic                 is_write;
    logic [TICK_W-1:0]    lead_ticks_reg;
    logic [TICK_W-1:0]    tail_ticks_reg;
    msp_timing_t          timing;
    logic [DUTY_BITS-1:0] step;
    logic [CHANNELS-1:0]  match;
    msp_frame_t           frame_cur;
    msp_frame_t           frame_nxt;
    logic                 rsp_valid_reg;
    msp_out_t             rsp_word_reg;

    // the result register frees up whenever its word is taken, so a new
    // request goes in on the same edge that the old result leaves
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;
    assign is_tick   = fire && (req_word.kind == KIND_TICK);
    assign is_write  = fire && (req_word.kind == KIND_WRITE);

    // configuration registers, written only while idle per user; unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_ticks_reg <= LEAD_TICKS_RESET;
            tail_ticks_reg <= TAIL_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEAD_TICKS: lead_ticks_reg <= cfg_data;
                CFG_TAIL_TICKS: tail_ticks_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign timing.lead_ticks = lead_ticks_reg;
    assign timing.tail_ticks = tail_ticks_reg;

    // duty table; writes to channels past the last one are dropped inside
    msp_duty_table u_duty_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (is_write),
        .wr_channel (req_word.channel),
        .wr_duty    (req_word.duty_value),
        .step       (step),
        .match      (match)
    );

    // frame sequencer; a write word leaves phase, count and lines alone
    msp_frame_seq u_frame_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (is_tick),
        .timing (timing),
        .match  (match),
        .step   (step),
        .cur    (frame_cur),
        .nxt    (frame_nxt)
    );

    // result register: captures the state as it stands after the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            rsp_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_word_reg.servo_lines <= frame_nxt.lines;
            rsp_word_reg.frame_phase <= 2'(frame_nxt.phase);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // tail holds every line low, lead holds every line high
    `MSP_ASSERT_NOW(a_tail_low, frame_cur.phase == PH_TAIL, frame_cur.lines == '0)
    `MSP_ASSERT_NOW(a_lead_high, frame_cur.phase == PH_LEAD, frame_cur.lines == '1)
    // a duty write never moves the frame
    `MSP_ASSERT_NEXT(a_write_keeps_frame, is_write, $stable(frame_cur))
    // every accepted word shows up as a result next cycle
    `MSP_ASSERT_NEXT(a_fire_gives_result, fire, rsp_valid_reg)

endmodule
